// ===== rtl/lps_pkg.sv =====
// Shared types, constants and SOS step tables for the LED pattern sequencer.
package lps_pkg;

    // Command queue sizing
    localparam int QUEUE_DEPTH = 10;
    localparam int QI_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Pattern codes
    localparam logic [2:0] PAT_SLOW  = 3'd0;
    localparam logic [2:0] PAT_FAST  = 3'd1;
    localparam logic [2:0] PAT_SOLID = 3'd2;
    localparam logic [2:0] PAT_SOS   = 3'd3;
    localparam logic [2:0] PAT_OFF   = 3'd4;

    // Item kinds carried in tuser
    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_CMD  = 1'b1;

    // Timing constants in milliseconds, then the SOS step count and last step index
    localparam logic [15:0] SLOW_DEF_MS  = 16'd1000;
    localparam logic [15:0] FAST_DEF_MS  = 16'd200;
    localparam logic [15:0] STEADY_MS    = 16'd100;
    localparam logic [4:0]  SOS_STEPS    = 5'd21;
    localparam logic [4:0]  SOS_LAST     = 5'd20;

    // One queued command
    typedef struct packed {
        logic [2:0]  pattern;
        logic [15:0] rate_ms;
    } t_cmd;

    // Queue status seen by the pattern engine
    typedef struct packed {
        logic has_cmd;
        t_cmd head;
    } t_q_status;

    // LED level of an SOS step
    function automatic logic sos_level(input logic [4:0] step);
        logic lvl;
        case (step) inside
            5'd0, 5'd2, 5'd4, 5'd7, 5'd9, 5'd11, 5'd14, 5'd16, 5'd18: lvl = 1'b1;
            default: lvl = 1'b0;
        endcase
        return lvl;
    endfunction

    // Duration of an SOS step
    function automatic logic [15:0] sos_ms(input logic [4:0] step);
        logic [15:0] ms;
        case (step) inside
            5'd7, 5'd9, 5'd11: ms = 16'd600;
            5'd6, 5'd13:       ms = 16'd300;
            5'd20:             ms = 16'd1000;
            default:           ms = 16'd200;
        endcase
        return ms;
    endfunction

endpackage

// ===== rtl/lps_cmd_queue.sv =====
// Front end: the circular command queue.
module lps_cmd_queue
    import lps_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,      // accepted command request
    input  t_cmd      i_cmd,
    input  logic      i_pop,       // engine consumes the head
    output logic      o_refused,   // push while full
    output t_q_status o_status
);

    localparam int SUM_W = CNT_W + 1;

    t_cmd             r_fifo [QUEUE_DEPTH];
    logic [QI_W-1:0]  r_head, n_head;
    logic [CNT_W-1:0] r_count, n_count;
    logic             full;
    logic [SUM_W-1:0] tail_sum;
    logic [QI_W-1:0]  tail;

    assign full      = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_refused = i_push && full;

    // Tail index, wrapped once (sum stays below twice the depth)
    always_comb begin
        tail_sum = SUM_W'(r_head) + SUM_W'(r_count);
        if (tail_sum >= SUM_W'(QUEUE_DEPTH))
            tail_sum = tail_sum - SUM_W'(QUEUE_DEPTH);
        tail = tail_sum[QI_W-1:0];
    end

    // Pointer and fill count updates
    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (i_push && !full)
            n_count = r_count + CNT_W'(1);
        if (i_pop) begin
            n_head  = (r_head == QI_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + QI_W'(1);
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // Entry storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_push && !full)
            r_fifo[tail] <= i_cmd;
    end

    assign o_status.has_cmd = (r_count != '0);
    assign o_status.head    = r_fifo[r_head];

    // A push that fits grows the queue by one
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !full |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("queue count did not grow on push");

    // The engine never pops an empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("pop from empty queue");

endmodule

// ===== rtl/lps_pattern_engine.sv =====
// Back end: pattern timing, command application and the SOS sequence.
module lps_pattern_engine
    import lps_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_tick,       // accepted 1 ms tick
    input  t_q_status  i_status,
    output logic       o_pop,
    output logic       o_led_next,   // LED level after this cycle's request
    output logic [2:0] o_mode_next
);

    logic [2:0]  r_mode, n_mode;
    logic [15:0] r_half, n_half;
    logic        r_led, n_led;
    logic [15:0] r_wait, n_wait;
    logic [4:0]  r_step, n_step;
    logic        boundary;
    logic [15:0] dur;
    logic [4:0]  s;

    assign boundary = i_tick && (r_wait == '0);
    assign o_pop    = boundary && !(r_mode == PAT_SOS && r_step != '0) && i_status.has_cmd;

    always_comb begin
        n_mode = r_mode;
        n_half = r_half;
        n_led  = r_led;
        n_wait = r_wait;
        n_step = r_step;
        dur    = r_wait;
        s      = (r_step < SOS_STEPS) ? r_step : '0;

        // Apply the head command at a boundary
        if (o_pop) begin
            case (i_status.head.pattern)
                PAT_SLOW: begin
                    n_mode = PAT_SLOW;
                    n_half = (i_status.head.rate_ms != '0) ? i_status.head.rate_ms
                                                           : SLOW_DEF_MS;
                end
                PAT_FAST: begin
                    n_mode = PAT_FAST;
                    n_half = (i_status.head.rate_ms != '0) ? i_status.head.rate_ms
                                                           : FAST_DEF_MS;
                end
                PAT_SOLID: n_mode = PAT_SOLID;
                PAT_SOS:   n_mode = PAT_SOS;
                PAT_OFF:   n_mode = PAT_OFF;
                default:   ;
            endcase
        end

        // Run one step of the (new) pattern
        if (boundary) begin
            case (n_mode)
                PAT_SLOW, PAT_FAST: begin
                    n_led = ~r_led;
                    dur   = n_half;
                end
                PAT_SOLID: begin
                    n_led = 1'b1;
                    dur   = STEADY_MS;
                end
                PAT_SOS: begin
                    n_led  = sos_level(s);
                    dur    = sos_ms(s);
                    n_step = (s == SOS_LAST) ? '0 : s + 5'd1;
                end
                default: begin
                    n_led = 1'b0;
                    dur   = STEADY_MS;
                end
            endcase
        end

        // Count the millisecond down
        if (i_tick)
            n_wait = (dur != '0) ? dur - 16'd1 : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= PAT_SLOW;
            r_half <= SLOW_DEF_MS;
            r_led  <= 1'b1;
            r_wait <= '0;
            r_step <= '0;
        end else begin
            r_mode <= n_mode;
            r_half <= n_half;
            r_led  <= n_led;
            r_wait <= n_wait;
            r_step <= n_step;
        end
    end

    assign o_led_next  = n_led;
    assign o_mode_next = n_mode;

    // A running wait loses exactly one per tick
    a_wait_countdown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tick && r_wait != '0 |=> r_wait == $past(r_wait) - 16'd1)
        else $error("wait counter skipped");

    // SOS step index stays inside the sequence
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step < SOS_STEPS)
        else $error("SOS step out of range");

    // Mid-sequence SOS takes no command
    a_sos_locked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == PAT_SOS && r_step != '0 |-> !o_pop)
        else $error("command popped inside SOS sequence");

endmodule

// ===== rtl/led_pattern_sequencer.sv =====
// Top level of the LED pattern sequencer: stream ports and the result buffer.
//
// Usage:
//   Slave stream carries requests: tuser = 0 is a 1 ms tick, tuser = 1 is a
//   pattern command with pattern and rate_ms in tdata. Every request yields
//   exactly one result on the master stream: LED level, a refused flag for a
//   command dropped on a full queue, and the pattern now running.
//   Commands wait in a 10-entry queue and are applied at the next pattern
//   boundary (a tick whose wait has run out); SOS takes none mid-sequence.
// Output: each result is registered, in the skid register on a stall.
// Throughput: one request per cycle while s_axis_tready is high; the state
//   update of a request is a single step of the pattern engine and the queue.
// Reset: queue empty, slow blink at 1000 ms, LED lit; the first tick is a
//   boundary.
// Stall: a result waits in the output register while m_axis_tready is low;
//   one more request is taken into a skid register, after which
//   s_axis_tready drops until the master side drains.
module led_pattern_sequencer
    import lps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [2:0] pattern, [18:3] rate_ms, rest zero
    input  logic        s_axis_tuser,   // [0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [0] led_on, [1] refused, [4:2] active_pattern
);

    typedef struct packed {
        logic       led_on;
        logic       refused;
        logic [2:0] active_pattern;
    } t_result;

    logic      acc;
    logic      tick;
    logic      push;
    t_cmd      cmd;
    logic      refused;
    logic      pop;
    logic      led_next;
    logic [2:0] mode_next;
    t_q_status q_status;
    t_result   res;

    logic      r_out_valid;
    t_result   r_out;
    logic      r_skid_valid;
    t_result   r_skid;

    // Classify the accepted request
    assign acc  = s_axis_tvalid && s_axis_tready;
    assign tick = acc && (s_axis_tuser == ACT_TICK);
    assign push = acc && (s_axis_tuser == ACT_CMD);
    assign cmd.pattern = s_axis_tdata[2:0];
    assign cmd.rate_ms = s_axis_tdata[18:3];

    lps_cmd_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_cmd     (cmd),
        .i_pop     (pop),
        .o_refused (refused),
        .o_status  (q_status)
    );

    lps_pattern_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tick      (tick),
        .i_status    (q_status),
        .o_pop       (pop),
        .o_led_next  (led_next),
        .o_mode_next (mode_next)
    );

    assign res.led_on         = led_next;
    assign res.refused        = refused;
    assign res.active_pattern = mode_next;

    // Output register with one skid entry
    assign s_axis_tready = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || m_axis_tready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= acc;
            end
        end else if (acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || m_axis_tready) begin
            if (r_skid_valid)
                r_out <= r_skid;
            else if (acc)
                r_out <= res;
        end else if (acc) begin
            r_skid <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out.active_pattern, r_out.refused, r_out.led_on};

endmodule

// ===== dv/led_pattern_sequencer_tb.sv =====
// Self-checking testbench for the LED pattern sequencer stream block.
`timescale 1ns / 1ps

module led_pattern_sequencer_tb;
    import lps_pkg::*;

    localparam int QUIET_LIMIT = 1500;
    localparam int HOLD_CYCLES = 80;
    localparam int SETTLE_CYCLES = 8;
    // lit steps of the SOS sequence, bit n for step n
    localparam logic [20:0] SOS_LIT_MAP = 21'b001010100101010010101;

    // One request on the slave side
    typedef struct {
        logic        is_cmd;
        logic [2:0]  pat;
        logic [15:0] rate;
    } t_lamp_req;

    // One result on the master side
    typedef struct packed {
        logic       lit;
        logic       refused;
        logic [2:0] pat;
    } t_lamp;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // [2:0] pattern, [18:3] rate_ms, rest zero
    logic        s_axis_tuser = 1'b0; // [0] action
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // [0] led_on, [1] refused, [4:2] active_pattern

    led_pattern_sequencer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Stimulus queue and expected results
    t_lamp_req req_pend_q[$];
    t_lamp     lamp_exp_q[$];

    // Predicted block state
    logic [2:0]  lamp_mode = PAT_SLOW;
    logic [15:0] blink_ms = SLOW_DEF_MS;
    logic        lamp_lit = 1'b1;
    logic [15:0] ms_left = '0;
    logic [4:0]  sos_pos = '0;
    t_cmd        cmd_pend_q[$];

    // Handshake bookkeeping
    logic in_taken = 1'b0;
    int   snd_idle_pct = 0;
    int   rcv_idle_pct = 0;
    int   hold_token = 0;
    int   hold_seen = 0;
    int   hold_left = 0;
    int   quiet_cycles = 0;

    // Run statistics
    int       n_pushed = 0;
    int       n_taken = 0;
    int       n_checked = 0;
    int       n_ticks = 0;
    int       n_cmds = 0;
    int       n_refused = 0;
    int       n_fail = 0;
    logic [7:0] modes_seen = '0;

    // Duration of one SOS step in ms
    function automatic logic [15:0] sos_step_ms(input logic [4:0] pos);
        logic [15:0] ms;
        ms = FAST_DEF_MS;
        if (pos == SOS_LAST)
            ms = SLOW_DEF_MS;
        else if (pos == 5'd6 || pos == 5'd13)
            ms = 16'd300;
        else if (pos >= 5'd7 && pos <= 5'd11 && pos[0])
            ms = 16'd600;
        return ms;
    endfunction

    // Advance the predicted state by one request and return its result
    function automatic t_lamp lamp_advance(input t_lamp_req rq);
        t_lamp r;
        t_cmd  c;
        r.refused = 1'b0;
        if (rq.is_cmd == ACT_CMD) begin
            n_cmds++;
            if (cmd_pend_q.size() >= QUEUE_DEPTH) begin
                r.refused = 1'b1;
                n_refused++;
            end else begin
                c.pattern = rq.pat;
                c.rate_ms = rq.rate;
                cmd_pend_q.push_back(c);
            end
        end else begin
            n_ticks++;
            if (ms_left == 0) begin
                // boundary: SOS only takes a command before its first step
                if (!(lamp_mode == PAT_SOS && sos_pos != 0) && cmd_pend_q.size() > 0) begin
                    c = cmd_pend_q.pop_front();
                    case (c.pattern)
                        PAT_SLOW: begin
                            lamp_mode = PAT_SLOW;
                            blink_ms = (c.rate_ms != 0) ? c.rate_ms : SLOW_DEF_MS;
                        end
                        PAT_FAST: begin
                            lamp_mode = PAT_FAST;
                            blink_ms = (c.rate_ms != 0) ? c.rate_ms : FAST_DEF_MS;
                        end
                        PAT_SOLID, PAT_SOS, PAT_OFF: lamp_mode = c.pattern;
                        default: ;
                    endcase
                end
                case (lamp_mode)
                    PAT_SLOW, PAT_FAST: begin
                        lamp_lit = ~lamp_lit;
                        ms_left = blink_ms;
                    end
                    PAT_SOLID: begin
                        lamp_lit = 1'b1;
                        ms_left = STEADY_MS;
                    end
                    PAT_SOS: begin
                        lamp_lit = SOS_LIT_MAP[sos_pos];
                        ms_left = sos_step_ms(sos_pos);
                        sos_pos = (sos_pos == SOS_LAST) ? 5'd0 : sos_pos + 5'd1;
                    end
                    default: begin
                        lamp_lit = 1'b0;
                        ms_left = STEADY_MS;
                    end
                endcase
            end
            if (ms_left != 0)
                ms_left = ms_left - 16'd1;
        end
        modes_seen[lamp_mode] = 1'b1;
        r.lit = lamp_lit;
        r.pat = lamp_mode;
        return r;
    endfunction

    // Sender: offers queued requests, holds each until accepted
    always @(negedge i_clk) begin : sender
        t_lamp_req nx;
        if (s_axis_tvalid && !in_taken) begin
            // keep the request on the bus
        end else if (i_rst_n && req_pend_q.size() != 0
                     && $urandom_range(99) >= snd_idle_pct) begin
            nx = req_pend_q.pop_front();
            s_axis_tvalid <= 1'b1;
            s_axis_tuser <= nx.is_cmd;
            s_axis_tdata <= {5'b0, nx.rate, nx.pat};
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // Receiver: random stalls plus an occasional long hold-off
    always @(negedge i_clk) begin
        if (hold_seen != hold_token) begin
            hold_seen <= hold_token;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // Monitor: checks results, predicts accepted requests, watchdog
    always @(posedge i_clk) begin : monitor
        t_lamp     want;
        t_lamp     got;
        t_lamp_req rq;
        logic      in_acc;
        logic      out_acc;
        in_acc = i_rst_n && s_axis_tvalid && s_axis_tready;
        out_acc = i_rst_n && m_axis_tvalid && m_axis_tready;
        in_taken <= in_acc;
        if (out_acc) begin
            got.lit = m_axis_tdata[0];
            got.refused = m_axis_tdata[1];
            got.pat = m_axis_tdata[4:2];
            if (lamp_exp_q.size() == 0) begin
                $error("result with no request pending: tdata 0x%02h", m_axis_tdata);
                n_fail++;
            end else begin
                want = lamp_exp_q.pop_front();
                n_checked++;
                if (got.lit !== want.lit) begin
                    $error("led_on: expected %0d, got %0d", want.lit, got.lit);
                    n_fail++;
                end
                if (got.refused !== want.refused) begin
                    $error("refused: expected %0d, got %0d", want.refused, got.refused);
                    n_fail++;
                end
                if (got.pat !== want.pat) begin
                    $error("active_pattern: expected %0d, got %0d", want.pat, got.pat);
                    n_fail++;
                end
            end
        end
        if (in_acc) begin
            rq.is_cmd = s_axis_tuser;
            rq.pat = s_axis_tdata[2:0];
            rq.rate = s_axis_tdata[18:3];
            lamp_exp_q.push_back(lamp_advance(rq));
            n_taken++;
        end
        // watchdog on handshake progress
        if (i_rst_n) begin
            if (in_acc || out_acc)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout: no request or result moved for %0d cycles", QUIET_LIMIT);
                $display("led_pattern_sequencer_tb failed");
                $finish;
            end
        end
    end

    task automatic push_cmd(input logic [2:0] pat, input logic [15:0] rate);
        t_lamp_req rq;
        rq.is_cmd = ACT_CMD;
        rq.pat = pat;
        rq.rate = rate;
        req_pend_q.push_back(rq);
        n_pushed++;
    endtask

    // Ticks carry random junk in the unused fields
    task automatic push_ticks(input int n);
        t_lamp_req rq;
        repeat (n) begin
            rq.is_cmd = ACT_TICK;
            rq.pat = 3'($urandom_range(7));
            rq.rate = 16'($urandom_range(16'hFFFF));
            req_pend_q.push_back(rq);
            n_pushed++;
        end
    endtask

    // Mostly short blink rates so that boundaries come often
    task automatic push_rand_cmd(input bit allow_sos);
        int          r;
        logic [2:0]  pat;
        logic [15:0] rate;
        r = $urandom_range(99);
        if (allow_sos && r < 2)      pat = PAT_SOS;
        else if (r < 27)             pat = PAT_SLOW;
        else if (r < 52)             pat = PAT_FAST;
        else if (r < 67)             pat = PAT_SOLID;
        else if (r < 82)             pat = PAT_OFF;
        else                         pat = 3'($urandom_range(5, 7));
        if (pat == PAT_SLOW || pat == PAT_FAST) begin
            r = $urandom_range(99);
            if ((pat == PAT_FAST && r < 5) || r < 1)
                rate = '0;
            else
                rate = 16'($urandom_range(1, 24));
        end else begin
            rate = 16'($urandom_range(16'hFFFF));
        end
        push_cmd(pat, rate);
    endtask

    // Random mix of command bursts and tick runs
    task automatic gen_mix(input int n);
        int left;
        int k;
        int pick;
        left = n;
        while (left > 0) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                k = $urandom_range(1, 3);
                repeat (k) push_rand_cmd(1'b1);
                left -= k;
            end else begin
                k = (pick < 90) ? $urandom_range(1, 40) : $urandom_range(90, 220);
                if (k > left)
                    k = left;
                push_ticks(k);
                left -= k;
            end
        end
    endtask

    // Block the sender until every request has its result
    task automatic wait_drained();
        do @(negedge i_clk); while (n_taken != n_pushed || lamp_exp_q.size() != 0);
        @(posedge i_clk);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: fill the queue before the first boundary, then overflow it
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        hold_token++;
        push_cmd(PAT_FAST, 16'd1);
        push_cmd(PAT_SLOW, 16'd2);
        push_cmd(PAT_SOLID, 16'd0);
        push_cmd(PAT_OFF, 16'd0);
        push_cmd(3'd5, 16'hFFFF);
        push_cmd(3'd6, 16'hAAAA);
        push_cmd(3'd7, 16'h5555);
        push_cmd(PAT_FAST, 16'd0);
        push_cmd(PAT_FAST, 16'd3);
        push_cmd(PAT_SLOW, 16'd4);
        push_cmd(PAT_SOS, 16'd0);
        push_cmd(PAT_SOLID, 16'hFFFF);
        push_ticks(720);
        wait_drained();

        // Random phases, each with a sender pause in the middle
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin snd_idle_pct = 0;  rcv_idle_pct = 0;  end
                1: begin snd_idle_pct = 47; rcv_idle_pct = 0;  end
                2: begin snd_idle_pct = 0;  rcv_idle_pct = 47; end
                default: begin snd_idle_pct = 35; rcv_idle_pct = 35; end
            endcase
            if (ph == 0)
                hold_token++;
            gen_mix(90);
            wait_drained();
            gen_mix(90);
            wait_drained();
        end

        // SOS start with commands arriving mid-sequence
        snd_idle_pct = 35;
        rcv_idle_pct = 35;
        push_cmd(PAT_SOS, 16'd0);
        push_cmd(PAT_FAST, 16'd5);
        push_ticks(40);
        repeat (10) push_rand_cmd(1'b0);
        push_ticks(300);
        wait_drained();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("checked %0d results: %0d ticks, %0d commands, %0d refused",
                 n_checked, n_ticks, n_cmds, n_refused);
        $display("patterns reached (bit per code): %05b", modes_seen[4:0]);
        if (n_fail == 0) begin
            $display("led_pattern_sequencer_tb passed");
        end else begin
            $display("led_pattern_sequencer_tb failed");
        end
        $finish;
    end

endmodule
